// ===== design/dds_tone_with_envelope_ramp_defines.svh =====
// Assertion macros shared by the checker of the tone generator.
`ifndef DDS_TONE_WITH_ENVELOPE_RAMP_DEFINES_SVH
`define DDS_TONE_WITH_ENVELOPE_RAMP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DTR_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DTR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/dtr_pkg.sv =====
// Types, constants and helpers of the DDS tone generator with envelope ramp.
`default_nettype none

package dtr_pkg;

   // table geometry
   localparam int TABLE_ADDR_BITS = 8;
   localparam int TABLE_DEPTH     = 1 << TABLE_ADDR_BITS;
   localparam int ENTRY_BITS      = 8;

   // datapath widths
   localparam int PHASE_BITS = 32;
   localparam int ENV_BITS   = 17;
   localparam int STEP_BITS  = 11;
   localparam int DIV_BITS   = 8;
   localparam int DUTY_BITS  = 8;
   localparam int TICK_BITS  = 32;
   localparam int KIND_BITS  = 3;
   localparam int PROD_BITS  = 17;

   // port widths
   localparam int REQ_TDATA_BITS = 16;
   localparam int RSP_TDATA_BITS = 48;
   localparam int CSR_DATA_BITS  = 32;
   localparam int CSR_INDEX_BITS = 2;

   // reset values and limits
   localparam logic [ENV_BITS-1:0]  ENV_LIMIT      = 17'h0ff00;
   localparam logic [STEP_BITS-1:0] STEP_RESET     = 11'd1048;
   localparam logic [DIV_BITS-1:0]  DIVIDE_RESET   = 8'd62;
   localparam logic [DUTY_BITS-1:0] DUTY_SILENCE   = 8'd128;

   // item kinds on req_tuser
   typedef enum logic [KIND_BITS-1:0] {
      KIND_TICK        = 3'd0,
      KIND_TONE_ON     = 3'd1,
      KIND_TONE_OFF    = 3'd2,
      KIND_PHASE_RESET = 3'd3,
      KIND_LOAD_SINE   = 3'd4,
      KIND_LOAD_SHAPE  = 3'd5
   } kind_type;

   // configuration register indexes
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_PHASE_INC = 2'd0,
      CSR_ENV_STEP  = 2'd1,
      CSR_TICK_DIV  = 2'd2
   } csr_index_type;

   // how the second stage forms the duty value
   typedef enum logic [2:0] {
      MODE_HOLD,
      MODE_RISE,
      MODE_FALL,
      MODE_SINE,
      MODE_SILENCE
   } duty_mode_type;

   // control travelling alongside the table reads
   typedef struct packed {
      duty_mode_type          mode;
      logic                   tone_active;
      logic [TICK_BITS-1:0]   tick_count;
   } stage_ctrl_type;

   // floor(p/256)+128 kept to 8 bits: bits 15:8 with the top one flipped
   function automatic logic [DUTY_BITS-1:0] scale_duty(input logic signed [PROD_BITS-1:0] p);
      return {~p[15], p[14:8]};
   endfunction

   // shape table index: envelope upper byte, saturated
   function automatic logic [TABLE_ADDR_BITS-1:0] shape_index(input logic [ENV_BITS-1:0] env);
      logic [ENV_BITS-9:0] upper;
      upper = env[ENV_BITS-1:8];
      if (upper > ENV_BITS'(TABLE_DEPTH - 1)) begin
         return TABLE_ADDR_BITS'(TABLE_DEPTH - 1);
      end
      return upper[TABLE_ADDR_BITS-1:0];
   endfunction

endpackage

`default_nettype wire

// ===== design/dds_tone_with_envelope_ramp.sv =====
// Top level of the DDS tone generator with amplitude envelope ramp.
// An accepted beat gives its result beat through the table read, then the output register.
// One beat per cycle if rsp_tready allows; sine and shape RAMs each take one read per beat.
// Reset (synchronous): phase, envelope and counters clear, duty 128, prescaler 62.
// Table contents are not cleared by reset and must be loaded before use.
`default_nettype none

module dds_tone_with_envelope_ramp import dtr_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   // req_tdata: table_index [7:0], entry_bits [15:8]
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [REQ_TDATA_BITS-1:0] req_tdata,
   // req_tuser: kind [2:0]
   input  logic [KIND_BITS-1:0]      req_tuser,
   // rsp_tdata: duty [7:0], tone_active [8], tick_count [40:9], zero [47:41]
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [RSP_TDATA_BITS-1:0] rsp_tdata,
   // rsp_tuser: duty_written [0]
   output logic                      rsp_tuser,
   input  logic                      csr_wr_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   // configuration registers
   logic [PHASE_BITS-1:0] phase_inc_ff;
   logic [STEP_BITS-1:0]  env_step_ff;
   logic [DIV_BITS-1:0]   tick_div_ff;

   // scalar tone state
   logic [PHASE_BITS-1:0] phase_ff, phase_in;
   logic [ENV_BITS-1:0]   env_ff, env_in;
   logic                  falling_ff, falling_in;
   logic                  active_ff, active_in;
   logic [DIV_BITS-1:0]   presc_ff, presc_in;
   logic [TICK_BITS-1:0]  coarse_ff, coarse_in;

   // second stage and output
   logic                  s1_valid_ff, s1_valid_in;
   stage_ctrl_type        s1_ctrl_ff, s1_ctrl_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [DUTY_BITS-1:0]  duty_ff, duty_in;
   logic                  written_ff;
   logic                  rsp_active_ff;
   logic [TICK_BITS-1:0]  rsp_ticks_ff;

   // beat fields and handshake
   kind_type                   kind;
   logic [TABLE_ADDR_BITS-1:0] table_index;
   logic [ENTRY_BITS-1:0]      entry_bits;
   logic                       in_beat;
   logic                       s1_advance;

   // table access
   logic [PHASE_BITS-1:0]      phase_sum;
   logic [ENV_BITS-1:0]        env_sum;
   logic [DIV_BITS-1:0]        presc_dec;
   duty_mode_type              mode;
   logic                       sine_wr, shape_wr;
   logic [ENTRY_BITS-1:0]      sine_q, shape_q;
   logic [ENTRY_BITS-1:0]      shape_eff;
   logic signed [PROD_BITS-1:0] product;
   logic [DUTY_BITS-1:0]       duty_new;

   assign kind        = kind_type'(req_tuser);
   assign table_index = req_tdata[TABLE_ADDR_BITS-1:0];
   assign entry_bits  = req_tdata[TABLE_ADDR_BITS +: ENTRY_BITS];

   // pipeline flow: a stage moves when the one after it is free or draining
   assign s1_advance = !rsp_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || s1_advance;
   assign in_beat    = req_tvalid && req_tready;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_inc_ff <= '0;
         env_step_ff  <= STEP_RESET;
         tick_div_ff  <= DIVIDE_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_PHASE_INC: phase_inc_ff <= csr_wdata[PHASE_BITS-1:0];
            CSR_ENV_STEP:  env_step_ff  <= csr_wdata[STEP_BITS-1:0];
            CSR_TICK_DIV:  tick_div_ff  <= csr_wdata[DIV_BITS-1:0];
            default: ;
         endcase
      end
   end

   assign phase_sum = phase_ff + phase_inc_ff;
   assign env_sum   = env_ff + ENV_BITS'(env_step_ff);
   assign presc_dec = presc_ff - 1'b1;

   // first stage: update scalar state, pick the duty rule, address the tables
   always_comb begin
      phase_in   = phase_ff;
      env_in     = env_ff;
      falling_in = falling_ff;
      active_in  = active_ff;
      presc_in   = presc_ff;
      coarse_in  = coarse_ff;
      mode       = MODE_HOLD;
      sine_wr    = 1'b0;
      shape_wr   = 1'b0;
      if (in_beat) begin
         unique case (kind)
            KIND_TICK: begin
               presc_in = presc_dec;
               if (presc_dec == '0) begin
                  coarse_in = coarse_ff + 1'b1;
                  presc_in  = tick_div_ff;
               end
               if (active_ff) begin
                  phase_in = phase_sum;
                  if (env_ff < ENV_LIMIT) begin
                     env_in = env_sum;
                     mode   = falling_ff ? MODE_FALL : MODE_RISE;
                  end else if (falling_ff) begin
                     mode      = MODE_SILENCE;
                     active_in = 1'b0;
                  end else begin
                     mode = MODE_SINE;
                  end
               end
            end
            KIND_TONE_ON: begin
               env_in     = '0;
               falling_in = 1'b0;
               active_in  = 1'b1;
            end
            KIND_TONE_OFF: begin
               env_in     = '0;
               falling_in = 1'b1;
            end
            KIND_PHASE_RESET: begin
               phase_in = '0;
               mode     = MODE_SILENCE;
            end
            KIND_LOAD_SINE:  sine_wr  = 1'b1;
            KIND_LOAD_SHAPE: shape_wr = 1'b1;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= '0;
         env_ff     <= '0;
         falling_ff <= 1'b0;
         active_ff  <= 1'b0;
         presc_ff   <= DIVIDE_RESET;
         coarse_ff  <= '0;
      end else begin
         phase_ff   <= phase_in;
         env_ff     <= env_in;
         falling_ff <= falling_in;
         active_ff  <= active_in;
         presc_ff   <= presc_in;
         coarse_ff  <= coarse_in;
      end
   end

   // tables: written by load beats, read by every accepted beat
   dtr_ram #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (TABLE_DEPTH)
   ) u_sine_ram (
      .clock   (clock),
      .wr_en   (sine_wr),
      .wr_addr (table_index),
      .wr_data (entry_bits),
      .rd_en   (in_beat),
      .rd_addr (phase_sum[PHASE_BITS-1 -: TABLE_ADDR_BITS]),
      .rd_data (sine_q)
   );

   dtr_ram #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (TABLE_DEPTH)
   ) u_shape_ram (
      .clock   (clock),
      .wr_en   (shape_wr),
      .wr_addr (table_index),
      .wr_data (entry_bits),
      .rd_en   (in_beat),
      .rd_addr (shape_index(env_sum)),
      .rd_data (shape_q)
   );

   // stage control alongside the reads
   always_comb begin
      s1_valid_in = s1_advance ? 1'b0 : s1_valid_ff;
      s1_ctrl_in  = s1_ctrl_ff;
      if (in_beat) begin
         s1_valid_in            = 1'b1;
         s1_ctrl_in.mode        = mode;
         s1_ctrl_in.tone_active = active_in;
         s1_ctrl_in.tick_count  = coarse_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ctrl_ff <= s1_ctrl_in;
   end

   // second stage: sine times shape (inverted on fall) when ramping; else sine, silence or hold
   assign shape_eff = (s1_ctrl_ff.mode == MODE_FALL) ? ~shape_q : shape_q;
   assign product   = PROD_BITS'($signed(sine_q) * $signed({1'b0, shape_eff}));

   always_comb begin
      case (s1_ctrl_ff.mode) inside
         MODE_RISE, MODE_FALL: duty_new = scale_duty(product);
         MODE_SINE:            duty_new = {~sine_q[ENTRY_BITS-1], sine_q[ENTRY_BITS-2:0]};
         MODE_SILENCE:         duty_new = DUTY_SILENCE;
         default:              duty_new = duty_ff;
      endcase
   end

   // output register; the duty register doubles as the held duty state
   assign rsp_valid_in = s1_advance ? s1_valid_ff : rsp_valid_ff;
   assign duty_in      = (s1_advance && s1_valid_ff) ? duty_new : duty_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         duty_ff      <= DUTY_SILENCE;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         duty_ff      <= duty_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance && s1_valid_ff) begin
         written_ff    <= (s1_ctrl_ff.mode != MODE_HOLD);
         rsp_active_ff <= s1_ctrl_ff.tone_active;
         rsp_ticks_ff  <= s1_ctrl_ff.tick_count;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = written_ff;
   assign rsp_tdata  = {(RSP_TDATA_BITS - TICK_BITS - 1 - DUTY_BITS)'(0),
                        rsp_ticks_ff, rsp_active_ff, duty_ff};

endmodule

`default_nettype wire

// ===== design/dtr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module dtr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int ADDR_BITS = $clog2(DEPTH)
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, data held while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== design/dtr_checker.sv =====
// Port-level checker of the tone generator, bound to the top level.
`default_nettype none

`include "dds_tone_with_envelope_ramp_defines.svh"

module dtr_checker import dtr_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   input  logic                      req_tready,
   input  logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   input  logic [RSP_TDATA_BITS-1:0] rsp_tdata,
   input  logic                      rsp_tuser
);

   logic [2:0] count_ff, count_in;
   logic       in_beat, out_beat;

   assign in_beat  = req_tvalid && req_tready;
   assign out_beat = rsp_tvalid && rsp_tready;

   // beats accepted but not yet answered
   assign count_in = 3'(count_ff + {2'b0, in_beat} - {2'b0, out_beat});

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   `DTR_ASSERT_NEXT(a_reset_clears_rsp, clock, 1'b0, reset, !rsp_tvalid, "rsp valid after reset")
   `DTR_ASSERT_NEXT(a_rsp_holds, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "stalled rsp beat changed")
   `DTR_ASSERT_NOW(a_stop_is_silence, clock, reset, rsp_tvalid && rsp_tuser && !rsp_tdata[DUTY_BITS], rsp_tdata[DUTY_BITS-1:0] == DUTY_SILENCE, "duty written while idle is not silence")
   `DTR_ASSERT_NOW(a_depth_bound, clock, reset, 1'b1, count_ff <= 3'd2, "more beats in flight than stages")
   `DTR_ASSERT_NOW(a_no_phantom_rsp, clock, reset, rsp_tvalid, count_ff != 3'd0, "rsp beat without a request")

endmodule

bind dds_tone_with_envelope_ramp dtr_checker u_dtr_checker (.*);

`default_nettype wire
